>>> rtl/kufe_pkg.sv
`default_nettype none

package kufe_pkg;

  localparam int unsigned NODE_IDX_W    = 10;
  localparam int unsigned WEIGHT_W      = 32;
  localparam int unsigned TOTAL_W       = 48;
  localparam int unsigned MAX_NODES_DEF = 1024;
  // Graph tag kept with each parent entry; a full sweep runs when it wraps
  localparam int unsigned EPOCH_W       = 4;

  typedef struct packed {
    logic [NODE_IDX_W-1:0] edge_from;
    logic [NODE_IDX_W-1:0] edge_to;
    logic [WEIGHT_W-1:0]   edge_weight;
    logic                  last;
  } edge_in_t;

  typedef struct packed {
    logic               taken;
    logic [TOTAL_W-1:0] tree_total;
    logic               final_res;
  } result_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_A,
    S_WALK_B,
    S_LINK
  } state_e;

  typedef struct packed {
    logic load;    // capture edge, start walk at first endpoint
    logic step;    // move current node to its parent
    logic root_a;  // keep first root, start walk at second endpoint
    logic commit;  // link roots, update total, load result register
    logic sweep;   // write one identity entry of the parent memory
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic root_hit;
    logic sweep_done;
    logic wrap;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/kruskal_union_find_engine_core.sv
// Channel  Direction  Handshake                  Payload
// edge     in         in_valid_i / in_stall_o    in_data_i  (kufe_pkg::edge_in_t)
// result   out        out_valid_o / out_stall_i  out_data_o (kufe_pkg::result_t)
//
// Each edge is loaded, walked from each endpoint up to its root, then linked;
// one memory read per parent hop.
// An edge with an endpoint out of range skips both walks and goes to the link step.
// After reset every entry of the parent memory is swept before the first edge;
// the same sweep follows every 16th final edge when the graph tag wraps.
// A stalled result holds the link step, so no further edge is taken meanwhile.
`default_nettype none

module kruskal_union_find_engine_core #(
  parameter int unsigned MAX_NODES = kufe_pkg::MAX_NODES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  kufe_pkg::edge_in_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output kufe_pkg::result_t   out_data_o
);

  kufe_pkg::cmd_t    cmd;
  kufe_pkg::status_t status;

  kufe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kufe_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/kufe_ctrl.sv
`default_nettype none

module kufe_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  input  kufe_pkg::status_t  status_i,
  output kufe_pkg::cmd_t     cmd_o
);

  kufe_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kufe_pkg::S_CLEAR: begin
        if (status_i.sweep_done) state_d = kufe_pkg::S_IDLE;
      end
      kufe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_range ? kufe_pkg::S_WALK_A : kufe_pkg::S_LINK;
        end
      end
      kufe_pkg::S_WALK_A: begin
        if (status_i.root_hit) state_d = kufe_pkg::S_WALK_B;
      end
      kufe_pkg::S_WALK_B: begin
        if (status_i.root_hit) state_d = kufe_pkg::S_LINK;
      end
      kufe_pkg::S_LINK: begin
        if (out_free) state_d = status_i.wrap ? kufe_pkg::S_CLEAR : kufe_pkg::S_IDLE;
      end
      default: state_d = kufe_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      kufe_pkg::S_CLEAR: cmd_o.sweep = 1'b1;
      kufe_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      kufe_pkg::S_WALK_A: begin
        cmd_o.root_a = status_i.root_hit;
        cmd_o.step   = !status_i.root_hit;
      end
      kufe_pkg::S_WALK_B: cmd_o.step = !status_i.root_hit;
      kufe_pkg::S_LINK:   cmd_o.commit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kufe_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_result_from_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == kufe_pkg::S_LINK))
    else $error("result appeared outside the link step");

  a_wrap_sweeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && status_i.wrap) |=> (state_q == kufe_pkg::S_CLEAR))
    else $error("tag wrap did not start a sweep");

  a_load_walks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == kufe_pkg::S_WALK_A || state_q == kufe_pkg::S_LINK))
    else $error("accepted edge did not start a walk");

endmodule

`default_nettype wire

>>> rtl/kufe_dp.sv
`default_nettype none

module kufe_dp #(
  parameter int unsigned MAX_NODES = kufe_pkg::MAX_NODES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  kufe_pkg::edge_in_t  in_data_i,
  input  kufe_pkg::cmd_t      cmd_i,
  output kufe_pkg::status_t   status_o,
  output kufe_pkg::result_t   out_data_o
);

  localparam int unsigned PTR_W  = $clog2(MAX_NODES);
  localparam int unsigned WIDE_W = (PTR_W > kufe_pkg::NODE_IDX_W) ? PTR_W
                                                                  : kufe_pkg::NODE_IDX_W;
  localparam int unsigned ENT_W  = kufe_pkg::EPOCH_W + PTR_W;
  localparam int unsigned SUM_W  = kufe_pkg::TOTAL_W + 1;
  localparam logic [PTR_W-1:0]             LAST_IDX  = PTR_W'(MAX_NODES - 1);
  localparam logic [kufe_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

  logic [ENT_W-1:0] mem_q [MAX_NODES];
  logic [ENT_W-1:0] rd_q;

  logic [PTR_W-1:0] raddr, from_idx, to_idx, rd_par;
  logic [PTR_W-1:0] cur_q, b_idx_q, ra_q, sweep_q;
  logic [kufe_pkg::EPOCH_W-1:0] epoch_q, rd_tag;
  logic [kufe_pkg::WEIGHT_W-1:0] w_q;
  logic last_q, bad_q, take;
  logic [kufe_pkg::TOTAL_W-1:0] sum_q, sum_new;
  logic [SUM_W-1:0] sum_ext;
  kufe_pkg::result_t out_q;

  function automatic logic [PTR_W-1:0] idx_of(logic [kufe_pkg::NODE_IDX_W-1:0] v);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(v);
    return wide[PTR_W-1:0];
  endfunction

  assign from_idx = idx_of(in_data_i.edge_from);
  assign to_idx   = idx_of(in_data_i.edge_to);
  assign rd_tag   = rd_q[ENT_W-1:PTR_W];
  assign rd_par   = rd_q[PTR_W-1:0];

  // An entry tagged by an older graph reads as its own index
  assign status_o.root_hit   = (rd_tag != epoch_q) || (rd_par == cur_q);
  assign status_o.in_range   = (32'(in_data_i.edge_from) < MAX_NODES) &&
                               (32'(in_data_i.edge_to) < MAX_NODES);
  assign status_o.sweep_done = (sweep_q == LAST_IDX);
  assign status_o.wrap       = last_q && (epoch_q == EPOCH_MAX);

  always_comb begin
    if (cmd_i.load) begin
      raddr = from_idx;
    end else if (cmd_i.root_a) begin
      raddr = b_idx_q;
    end else begin
      raddr = rd_par;
    end
  end

  // In the link step cur_q holds the second root
  assign take    = !bad_q && (ra_q != cur_q);
  assign sum_ext = {1'b0, sum_q} + SUM_W'(w_q);
  always_comb begin
    sum_new = sum_q;
    if (take) begin
      sum_new = sum_ext[kufe_pkg::TOTAL_W] ? '1 : sum_ext[kufe_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mem_q[sweep_q] <= {kufe_pkg::EPOCH_W'(0), sweep_q};
    end else if (cmd_i.commit && take) begin
      mem_q[ra_q] <= {epoch_q, cur_q};
    end
    rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q   <= from_idx;
      b_idx_q <= to_idx;
      w_q     <= in_data_i.edge_weight;
      last_q  <= in_data_i.last;
      bad_q   <= !status_o.in_range;
    end else if (cmd_i.step) begin
      cur_q <= rd_par;
    end else if (cmd_i.root_a) begin
      ra_q  <= cur_q;
      cur_q <= b_idx_q;
    end
    if (cmd_i.commit) begin
      out_q.taken      <= take;
      out_q.tree_total <= sum_new;
      out_q.final_res  <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      epoch_q <= '0;
      sweep_q <= '0;
    end else begin
      if (cmd_i.commit) begin
        sum_q <= last_q ? '0 : sum_new;
        // Advance the tag to retire the whole graph; wrap forces a sweep
        if (last_q) epoch_q <= epoch_q + 1'b1;
      end
      if (cmd_i.sweep) begin
        sweep_q <= status_o.sweep_done ? '0 : sweep_q + 1'b1;
      end
    end
  end

  assign out_data_o = out_q;

  a_last_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && last_q) |=> (sum_q == '0))
    else $error("total not cleared after final edge");

  a_sweep_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sweep |-> !(cmd_i.commit || cmd_i.load))
    else $error("edge work during memory sweep");

  a_wrap_to_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && status_o.wrap) |=> (epoch_q == '0 && sweep_q == '0))
    else $error("tag wrap left sweep state inconsistent");

endmodule

`default_nettype wire

>>> bench/kufe_mst_check.sv
`timescale 1ns / 100ps

module kufe_mst_check #(
  parameter int unsigned MAX_NODES = kufe_pkg::MAX_NODES_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_stall_i,
  input  kufe_pkg::edge_in_t  in_data_i,
  input  wire                 out_valid_i,
  input  wire                 out_stall_i,
  input  kufe_pkg::result_t   out_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         due_count_o,
  output int unsigned         checked_o,
  output int unsigned         taken_o
);

  localparam logic [kufe_pkg::TOTAL_W-1:0] SUM_CEIL = '1;

  logic [kufe_pkg::NODE_IDX_W-1:0] up_link [MAX_NODES];
  logic [kufe_pkg::TOTAL_W-1:0]    span_sum;
  kufe_pkg::result_t               results_due [$];
  kufe_pkg::result_t               want;

  function automatic void clear_graph();
    for (int unsigned k = 0; k < MAX_NODES; k++) begin
      up_link[k] = k[kufe_pkg::NODE_IDX_W-1:0];
    end
    span_sum = '0;
  endfunction

  // Walk parent links without compression; links only hang root under root.
  function automatic logic [kufe_pkg::NODE_IDX_W-1:0] root_of(
    input logic [kufe_pkg::NODE_IDX_W-1:0] node
  );
    logic [kufe_pkg::NODE_IDX_W-1:0] cur;
    cur = node;
    for (int unsigned hops = 0; hops < MAX_NODES; hops++) begin
      if (up_link[cur] == cur || up_link[cur] >= MAX_NODES) break;
      cur = up_link[cur];
    end
    return cur;
  endfunction

  function automatic kufe_pkg::result_t mst_step(input kufe_pkg::edge_in_t e);
    kufe_pkg::result_t               r;
    logic [kufe_pkg::NODE_IDX_W-1:0] ra;
    logic [kufe_pkg::NODE_IDX_W-1:0] rb;
    logic [kufe_pkg::TOTAL_W:0]      grown;
    r = '0;
    if (e.edge_from < MAX_NODES && e.edge_to < MAX_NODES) begin
      ra = root_of(e.edge_from);
      rb = root_of(e.edge_to);
      if (ra != rb) begin
        up_link[ra] = rb;
        grown = span_sum + e.edge_weight;
        span_sum = (grown > SUM_CEIL) ? SUM_CEIL : grown[kufe_pkg::TOTAL_W-1:0];
        r.taken = 1'b1;
      end
    end
    r.tree_total = span_sum;
    r.final_res  = e.last;
    // a final edge reports its total, then the graph starts over
    if (e.last) clear_graph();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_graph();
      results_due.delete();
      fail_count_o = 0;
      due_count_o  = 0;
      checked_o    = 0;
      taken_o      = 0;
    end else begin
      // predict first so an expectation is queued before its result is checked
      if (in_valid_i && !in_stall_i) begin
        want = mst_step(in_data_i);
        if (want.taken) taken_o++;
        results_due.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (results_due.size() == 0) begin
          $display("%0t: result with no edge pending, expected none, got %h",
                   $time, out_data_i);
          fail_count_o++;
        end else begin
          want = results_due.pop_front();
          if (out_data_i.taken !== want.taken) begin
            $display("%0t: taken expected %0b, got %0b", $time, want.taken, out_data_i.taken);
            fail_count_o++;
          end
          if (out_data_i.tree_total !== want.tree_total) begin
            $display("%0t: tree_total expected %h, got %h",
                     $time, want.tree_total, out_data_i.tree_total);
            fail_count_o++;
          end
          if (out_data_i.final_res !== want.final_res) begin
            $display("%0t: final_res expected %0b, got %0b",
                     $time, want.final_res, out_data_i.final_res);
            fail_count_o++;
          end
        end
      end
      due_count_o = results_due.size();
    end
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NODES        = kufe_pkg::MAX_NODES_DEF;
  localparam int unsigned EDGE_TARGET  = 750;
  // Worst case per edge: two walks of up to NODES hops, the longest result stall
  // and the longest send gap, plus a full memory sweep every 16th graph.
  localparam int unsigned CYCLE_LIMIT  = 5_000_000;
  // Longer than one sweep plus a deep edge, to catch stray results.
  localparam int unsigned DRAIN_CYCLES = 2200;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  kufe_pkg::edge_in_t in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  kufe_pkg::result_t  out_data;

  int unsigned fail_count;
  int unsigned due_count;
  int unsigned checked;
  int unsigned taken_count;
  int unsigned edges_sent  = 0;
  int unsigned graphs_sent = 0;
  int unsigned cycles      = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_pick;
  bit          calm_in     = 1'b0;
  bit          calm_out    = 1'b0;

  kruskal_union_find_engine_core #(.MAX_NODES(NODES)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  kufe_mst_check #(.MAX_NODES(NODES)) mst_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .due_count_o (due_count),
    .checked_o   (checked),
    .taken_o     (taken_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles with %0d results due", $time, cycles, due_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result-side stall: mostly short, a few long, with calm stretches.
  always @(negedge clk) begin
    if (cycles % 300 == 0) calm_out <= ($urandom_range(0, 3) == 0);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_out) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (stall_pick < 93) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_in || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called and returns at a falling edge.
  task automatic send_edge(input logic [kufe_pkg::NODE_IDX_W-1:0] from_node,
                           input logic [kufe_pkg::NODE_IDX_W-1:0] to_node,
                           input logic [kufe_pkg::WEIGHT_W-1:0]   weight,
                           input logic                            fin);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data.edge_from <= from_node;
    in_data.edge_to   <= to_node;
    in_data.edge_weight <= weight;
    in_data.last      <= fin;
    do @(posedge clk); while (in_stall);
    edges_sent++;
    if (fin) graphs_sent++;
    @(negedge clk);
  endtask

  // Hold off new edges until every outstanding result has been seen.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_count != 0);
  endtask

  // Random edges inside one node window, weights ascending.
  task automatic grow_forest(input int unsigned n, input int unsigned m);
    int unsigned     base;
    longint unsigned w;
    bit              close;
    base  = $urandom_range(0, NODES - n);
    w     = $urandom() >> $urandom_range(0, 31);
    close = ($urandom_range(0, 9) != 0);
    for (int unsigned k = 0; k < m; k++) begin
      send_edge(10'(base + $urandom_range(0, n - 1)),
                10'(base + $urandom_range(0, n - 1)),
                w[31:0], close && (k == m - 1));
      w += $urandom() >> $urandom_range(6, 31);
      if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
    end
  endtask

  // Linked in order, each edge hangs the whole chain under the next node, so
  // root walks grow one hop per edge; reversed order builds a star instead.
  task automatic build_chain(input int unsigned n);
    int unsigned     base;
    longint unsigned w;
    bit              forward;
    bit              close;
    base    = $urandom_range(0, NODES - n);
    w       = $urandom() >> $urandom_range(4, 31);
    forward = $urandom_range(0, 1);
    close   = ($urandom_range(0, 6) != 0);
    for (int unsigned k = 0; k + 1 < n; k++) begin
      if (forward) send_edge(10'(base + k), 10'(base + k + 1), w[31:0], 1'b0);
      else send_edge(10'(base + k + 1), 10'(base + k), w[31:0], 1'b0);
      w += $urandom_range(0, 4096);
      if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
    end
    for (int unsigned k = 0; k < 3; k++) begin
      send_edge(10'(base + $urandom_range(0, n / 4)), 10'(base + $urandom_range(0, n - 1)),
                w[31:0], close && (k == 2));
    end
  endtask

  // Unsorted edges anywhere, with self loops and stray final flags.
  task automatic send_noise(input int unsigned m);
    logic [kufe_pkg::NODE_IDX_W-1:0] a;
    for (int unsigned k = 0; k < m; k++) begin
      a = 10'($urandom_range(0, 1023));
      send_edge(a, ($urandom_range(0, 7) == 0) ? a : 10'($urandom_range(0, 1023)),
                $urandom(), $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    int unsigned pick;
    int unsigned size;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    calm_in = 1'b0;
    send_edge(10'd0,    10'd1,    32'h0000_0000, 1'b0);
    send_edge(10'd1023, 10'd1022, 32'h0000_0001, 1'b0);
    send_edge(10'd5,    10'd5,    32'h0000_0001, 1'b0);  // self loop
    send_edge(10'd1,    10'd0,    32'h0000_0002, 1'b0);  // already joined
    send_edge(10'd0,    10'd1023, 32'h0000_FFFF, 1'b0);  // merge two trees
    send_edge(10'd1022, 10'd1,    32'h0001_0000, 1'b0);  // joined through merge
    send_edge(10'h2AA,  10'h155,  32'h0001_0000, 1'b0);
    send_edge(10'h155,  10'd0,    32'hFFFF_FFFF, 1'b1);
    // same pair again must be taken once the graph has been cleared
    send_edge(10'd0,    10'd1,    32'hFFFF_FFFF, 1'b0);
    for (int k = 2; k < 12; k++) send_edge(10'(k), 10'(k + 1), 32'hFFFF_FFFF, 1'b0);
    send_edge(10'd2,    10'd12,   32'hFFFF_FFFF, 1'b0);  // deepest walk, joined
    send_edge(10'd0,    10'd2,    32'hFFFF_FFFF, 1'b0);
    send_edge(10'd12,   10'd0,    32'hFFFF_FFFF, 1'b0);
    send_edge(10'd7,    10'd7,    32'hFFFF_FFFF, 1'b1);  // final edge not taken
    send_edge(10'd1023, 10'd0,    32'h8000_0000, 1'b1);  // single-edge graph
    drain_results();

    while (edges_sent < EDGE_TARGET) begin
      calm_in = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        size = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 300) : $urandom_range(2, 24);
        grow_forest(size, $urandom_range(1, (2 * size < 60) ? 2 * size : 60));
      end else if (pick < 80) begin
        build_chain(($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) : $urandom_range(3, 16));
      end else begin
        send_noise($urandom_range(1, 12));
      end
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d edges closing %0d graphs; %0d edges joined trees, %0d results checked.",
             edges_sent, graphs_sent, taken_count, checked);
    $display("Mix: sorted forests, deep chains and stars, self loops, unsorted noise edges.");
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
rtl/kufe_pkg.sv
rtl/kufe_ctrl.sv
rtl/kufe_dp.sv
rtl/kruskal_union_find_engine_core.sv
bench/kufe_mst_check.sv
bench/tb_top.sv
